/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/vbcr_pkg.sv */
package vbcr_pkg;

   // Default number of return stack entries.
   localparam int NEST_DEPTH_DEFAULT = 16;

   // Field widths fixed by the interface.
   localparam int BLOCK_W = 32;
   localparam int DEPTH_OUT_W = 5;

   // Status flag masks.
   localparam logic [3:0] FLAG_ZERO  = 4'h1;
   localparam logic [3:0] FLAG_SIGN  = 4'h2;
   localparam logic [3:0] FLAG_CARRY = 4'h4;
   localparam logic [3:0] FLAG_OVFL  = 4'h8;

   typedef enum logic [2:0] {
      OP_JUMP = 3'd0,
      OP_JCC  = 3'd1,
      OP_CALL = 3'd2,
      OP_RET  = 3'd3,
      OP_HALT = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      CC_EQ = 4'd0,
      CC_NE = 4'd1,
      CC_LT = 4'd2,
      CC_GE = 4'd3,
      CC_LE = 4'd4,
      CC_GT = 4'd5,
      CC_B  = 4'd6,
      CC_AE = 4'd7,
      CC_BE = 4'd8,
      CC_A  = 4'd9
   } cond_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_OVER  = 2'd1,
      ERR_UNDER = 2'd2
   } err_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Evaluates a condition code over the status flags; unknown codes fail.
   function automatic logic cond_holds(input logic [3:0] flags, input logic [3:0] code);
      logic z;
      logic s;
      logic c;
      logic v;
      logic hit;
      z = (flags & FLAG_ZERO) != 4'h0;
      s = (flags & FLAG_SIGN) != 4'h0;
      c = (flags & FLAG_CARRY) != 4'h0;
      v = (flags & FLAG_OVFL) != 4'h0;
      unique case (code)
         CC_EQ:   hit = z;
         CC_NE:   hit = !z;
         CC_LT:   hit = s != v;
         CC_GE:   hit = s == v;
         CC_LE:   hit = z || (s != v);
         CC_GT:   hit = !z && (s == v);
         CC_B:    hit = c;
         CC_AE:   hit = !c;
         CC_BE:   hit = c || z;
         CC_A:    hit = !c && !z;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* rtl/vbcr_ram.sv */
module vbcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/vm_branch_call_return_unit.sv */
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+-------------------------------
// request   | req_operation, req_target_block,             | taken when start and not busy
//           | req_condition_code, req_status_flags,        |
//           | req_current_block                            |
// response  | rsp_taken, rsp_next_block, rsp_error_code,   | rsp_strobe, one cycle, no stall
//           | rsp_halted, rsp_stack_depth                  |
//
// Each word passes through an accept cycle and an execute cycle: the accept cycle reads the top of
// the return stack from the stack RAM, whose read data is registered, and the execute cycle updates the stack.
// The response appears in the cycle after the execute cycle, while the next word is taken.
// Reset is synchronous and clears the stack count, the halt flag and the control state;
// the stack RAM is not cleared because only entries written by a call are ever used.
// The receiver cannot stall, so the response strobe lasts exactly one cycle.
`include "assert_macros.svh"

module vm_branch_call_return_unit #(
   parameter int NEST_DEPTH = vbcr_pkg::NEST_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_operation,
   input  logic [vbcr_pkg::BLOCK_W-1:0]       req_target_block,
   input  logic [3:0]                         req_condition_code,
   input  logic [3:0]                         req_status_flags,
   input  logic [vbcr_pkg::BLOCK_W-1:0]       req_current_block,
   output logic                               rsp_strobe,
   output logic                               rsp_taken,
   output logic [vbcr_pkg::BLOCK_W-1:0]       rsp_next_block,
   output logic [1:0]                         rsp_error_code,
   output logic                               rsp_halted,
   output logic [vbcr_pkg::DEPTH_OUT_W-1:0]   rsp_stack_depth
);

   localparam int ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(NEST_DEPTH + 1);

   vbcr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                halt_ff, halt_in;

   // Captured request word.
   vbcr_pkg::op_type                op_ff;
   logic [vbcr_pkg::BLOCK_W-1:0]    target_ff;
   logic [3:0]                      code_ff;
   logic [3:0]                      flags_ff;
   logic [vbcr_pkg::BLOCK_W-1:0]    cur_ff;

   // Response registers.
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_taken_ff, rsp_taken_in;
   logic [vbcr_pkg::BLOCK_W-1:0]    rsp_next_ff, rsp_next_in;
   vbcr_pkg::err_type               rsp_err_ff, rsp_err_in;
   logic                            rsp_halted_ff;
   logic [vbcr_pkg::DEPTH_OUT_W-1:0] rsp_depth_ff;

   // Stack RAM ports.
   logic                            ram_wr_en;
   logic [ADDR_W-1:0]               ram_wr_addr;
   logic                            ram_rd_en;
   logic [ADDR_W-1:0]               ram_rd_addr;
   logic [vbcr_pkg::BLOCK_W-1:0]    ram_rd_data;

   logic accept;

   assign busy   = (state_ff == vbcr_pkg::ST_EXEC);
   assign accept = start && !busy;

   vbcr_ram #(
      .WIDTH (vbcr_pkg::BLOCK_W),
      .DEPTH (NEST_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state, stack update and response values.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      halt_in       = halt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ADDR_W'(count_ff);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ADDR_W'(count_ff - CNT_W'(1));
      rsp_strobe_in = 1'b0;
      rsp_taken_in  = 1'b0;
      rsp_next_in   = '0;
      rsp_err_in    = vbcr_pkg::ERR_NONE;
      unique case (state_ff)
         vbcr_pkg::ST_IDLE: begin
            // The top entry is read speculatively; only a return uses it.
            if (start) begin
               ram_rd_en = 1'b1;
               state_in  = vbcr_pkg::ST_EXEC;
            end
         end
         vbcr_pkg::ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = vbcr_pkg::ST_IDLE;
            unique case (op_ff)
               vbcr_pkg::OP_JUMP: begin
                  rsp_taken_in = 1'b1;
                  rsp_next_in  = target_ff;
               end
               vbcr_pkg::OP_JCC: begin
                  if (vbcr_pkg::cond_holds(flags_ff, code_ff)) begin
                     rsp_taken_in = 1'b1;
                     rsp_next_in  = target_ff;
                  end
               end
               vbcr_pkg::OP_CALL: begin
                  if (count_ff >= CNT_W'(NEST_DEPTH)) begin
                     rsp_err_in = vbcr_pkg::ERR_OVER;
                  end else begin
                     ram_wr_en    = 1'b1;
                     count_in     = count_ff + CNT_W'(1);
                     rsp_taken_in = 1'b1;
                     rsp_next_in  = target_ff;
                  end
               end
               vbcr_pkg::OP_RET: begin
                  if (count_ff == '0) begin
                     rsp_err_in = vbcr_pkg::ERR_UNDER;
                  end else begin
                     count_in     = count_ff - CNT_W'(1);
                     rsp_taken_in = 1'b1;
                     rsp_next_in  = ram_rd_data;
                  end
               end
               vbcr_pkg::OP_HALT: begin
                  halt_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = vbcr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vbcr_pkg::ST_IDLE;
         count_ff      <= '0;
         halt_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         halt_ff       <= halt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Request capture and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= vbcr_pkg::op_type'(req_operation);
         target_ff <= req_target_block;
         code_ff   <= req_condition_code;
         flags_ff  <= req_status_flags;
         cur_ff    <= req_current_block;
      end
      if (state_ff == vbcr_pkg::ST_EXEC) begin
         rsp_taken_ff  <= rsp_taken_in;
         rsp_next_ff   <= rsp_next_in;
         rsp_err_ff    <= rsp_err_in;
         rsp_halted_ff <= halt_in;
         rsp_depth_ff  <= vbcr_pkg::DEPTH_OUT_W'(count_in);
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_taken       = rsp_taken_ff;
   assign rsp_next_block  = rsp_next_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_stack_depth = rsp_depth_ff;

   // Checks on the stack bookkeeping and the response timing.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(NEST_DEPTH), "stack count beyond depth")
   `ASSERT_NEXT(a_exec_strobe, clock, reset, state_ff == vbcr_pkg::ST_EXEC, rsp_strobe_ff, "execute cycle gave no response")
   `ASSERT_NEXT(a_count_hold, clock, reset, state_ff != vbcr_pkg::ST_EXEC, $stable(count_ff), "stack count moved outside execute")
   `ASSERT_SAME(a_err_not_taken, clock, reset, rsp_strobe_ff && rsp_err_ff != vbcr_pkg::ERR_NONE, !rsp_taken_ff && rsp_next_ff == '0, "error response marked taken")

endmodule
